// ===== rtl/plce_pkg.sv =====
// ----------------------------------------------------------------------------
// plce_pkg: shared types and constants of the lock command engine
// Command and reply codes, protocol phases and the result record.
// ----------------------------------------------------------------------------
package plce_pkg;

  // Default number of key bytes.
  localparam int KEY_LENGTH_DEF = 5;

  // Command bytes received in the idle phase.
  localparam logic [7:0] CMD_QUERY  = 8'h51;  // 'Q'
  localparam logic [7:0] CMD_SET    = 8'h53;  // 'S'
  localparam logic [7:0] CMD_CHANGE = 8'h43;  // 'C'
  localparam logic [7:0] CMD_OPEN   = 8'h4F;  // 'O'
  localparam logic [7:0] CMD_CHECK  = 8'h41;  // 'A'
  localparam logic [7:0] CMD_TIME   = 8'h54;  // 'T'
  localparam logic [7:0] CMD_LOCK   = 8'h4C;  // 'L'

  // Reply bytes.
  localparam logic [7:0] REPLY_ONE  = 8'h31;  // '1'
  localparam logic [7:0] REPLY_ZERO = 8'h30;  // '0'
  localparam logic [7:0] REPLY_NOKEY = 8'h41; // 'A'

  // Reset values and limits.
  localparam logic [7:0] KEY_RESET_BYTE  = 8'h30;  // ASCII zero character
  localparam logic [7:0] HOLD_RESET      = 8'd10;
  localparam logic [3:0] TRY_LIMIT_RESET = 4'd3;
  localparam logic [7:0] FAIL_MAX        = 8'hFF;

  // Protocol phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SET,
    PH_CHANGE,
    PH_OPEN,
    PH_CHECK,
    PH_TIME
  } phase_t;

  // One result item.
  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       door_cycle;
    logic [7:0] hold_seconds;
    logic       alarm;
    logic       key_saved;
    logic       time_saved;
  } result_t;

endpackage

// ===== rtl/plce_key_compare.sv =====
// ----------------------------------------------------------------------------
// plce_key_compare: string-style key comparison
// Compares the entered bytes with the stored key in order; an equal zero
// byte ends the comparison as a match.
// ----------------------------------------------------------------------------
module plce_key_compare #(
  parameter int KEY_LENGTH = plce_pkg::KEY_LENGTH_DEF
) (
  input  logic [KEY_LENGTH-1:0][7:0] entry,
  input  logic [KEY_LENGTH-1:0][7:0] stored,
  output logic                       match
);

  logic [KEY_LENGTH-1:0] byte_eq;
  logic [KEY_LENGTH-1:0] byte_end;

  // Per-byte equality and terminator flags, evaluated in parallel.
  always_comb begin
    for (int i = 0; i < KEY_LENGTH; i++) begin
      byte_eq[i]  = (entry[i] == stored[i]);
      byte_end[i] = byte_eq[i] && (entry[i] == 8'h00);
    end
  end

  // A difference counts only if no equal terminator came before it.
  always_comb begin
    logic stopped;
    stopped = 1'b0;
    match   = 1'b1;
    for (int i = 0; i < KEY_LENGTH; i++) begin
      if (!stopped && !byte_eq[i]) begin
        match = 1'b0;
      end
      stopped = stopped | byte_end[i];
    end
  end

endmodule

// ===== rtl/plce_engine.sv =====
// ----------------------------------------------------------------------------
// plce_engine: lock protocol state and command decode
// Holds the protocol phase, key storage and counters, and computes the
// result of one byte in a single pass; state advances on each step.
// ----------------------------------------------------------------------------
module plce_engine #(
  parameter int KEY_LENGTH = plce_pkg::KEY_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic [3:0]       try_limit,
  output plce_pkg::result_t res
);

  import plce_pkg::*;

  localparam int CW = $clog2(KEY_LENGTH + 1);
  localparam int IW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;

  phase_t                    phase_r, phase_nxt;
  logic [CW-1:0]             byte_cnt_r, byte_cnt_nxt;
  logic [KEY_LENGTH-1:0][7:0] entry_r;
  logic [KEY_LENGTH-1:0][7:0] key_r;
  logic [KEY_LENGTH-1:0][7:0] cand;
  logic                      key_valid_r, key_valid_nxt;
  logic [7:0]                fail_r, fail_nxt;
  logic [7:0]                hold_r, hold_nxt;
  logic [7:0]                fail_inc;
  logic [IW-1:0]             idx;
  logic                      last_byte;
  logic                      collecting;
  logic                      store_key;
  logic                      match;

  assign idx        = byte_cnt_r[IW-1:0];
  assign last_byte  = (byte_cnt_r == CW'(KEY_LENGTH - 1));
  assign collecting = (phase_r == PH_SET) || (phase_r == PH_CHANGE) ||
                      (phase_r == PH_OPEN) || (phase_r == PH_CHECK);
  assign fail_inc   = (fail_r == FAIL_MAX) ? fail_r : fail_r + 8'd1;

  // Entered key as it stands after this byte.
  always_comb begin
    for (int i = 0; i < KEY_LENGTH; i++) begin
      cand[i] = (idx == IW'(i)) ? rx_byte : entry_r[i];
    end
  end

  plce_key_compare #(
    .KEY_LENGTH(KEY_LENGTH)
  ) u_cmp (
    .entry  (cand),
    .stored (key_r),
    .match  (match)
  );

  // Next phase and byte count.
  always_comb begin
    phase_nxt    = phase_r;
    byte_cnt_nxt = byte_cnt_r;
    unique case (phase_r)
      PH_IDLE: begin
        unique case (rx_byte)
          CMD_SET: begin
            phase_nxt    = PH_SET;
            byte_cnt_nxt = '0;
          end
          CMD_CHANGE: begin
            phase_nxt    = PH_CHANGE;
            byte_cnt_nxt = '0;
          end
          CMD_OPEN: begin
            if (key_valid_r) begin
              phase_nxt    = PH_OPEN;
              byte_cnt_nxt = '0;
            end
          end
          CMD_CHECK: begin
            if (key_valid_r) begin
              phase_nxt    = PH_CHECK;
              byte_cnt_nxt = '0;
            end
          end
          CMD_TIME: begin
            phase_nxt = PH_TIME;
          end
          default: begin
          end
        endcase
      end
      PH_TIME: begin
        phase_nxt = PH_IDLE;
      end
      PH_SET, PH_CHANGE, PH_OPEN, PH_CHECK: begin
        if (last_byte) begin
          phase_nxt    = PH_IDLE;
          byte_cnt_nxt = '0;
        end else begin
          byte_cnt_nxt = byte_cnt_r + CW'(1);
        end
      end
      default: begin
        phase_nxt    = PH_IDLE;
        byte_cnt_nxt = '0;
      end
    endcase
  end

  // Result fields and data state updates.
  always_comb begin
    res           = '0;
    key_valid_nxt = key_valid_r;
    fail_nxt      = fail_r;
    hold_nxt      = hold_r;
    store_key     = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        unique case (rx_byte)
          CMD_QUERY: begin
            res.reply_valid = 1'b1;
            res.reply_byte  = key_valid_r ? REPLY_ONE : REPLY_ZERO;
          end
          CMD_OPEN: begin
            if (!key_valid_r) begin
              res.reply_valid = 1'b1;
              res.reply_byte  = REPLY_ZERO;
            end
          end
          CMD_CHECK: begin
            if (!key_valid_r) begin
              res.reply_valid = 1'b1;
              res.reply_byte  = REPLY_NOKEY;
            end
          end
          CMD_LOCK: begin
            fail_nxt  = {4'd0, try_limit};
            res.alarm = 1'b1;
          end
          default: begin
          end
        endcase
      end
      PH_TIME: begin
        hold_nxt       = rx_byte;
        res.time_saved = 1'b1;
      end
      PH_SET, PH_CHANGE: begin
        if (last_byte) begin
          store_key     = 1'b1;
          key_valid_nxt = 1'b1;
          res.key_saved = 1'b1;
          if (phase_r == PH_CHANGE) begin
            res.reply_valid = 1'b1;
            res.reply_byte  = REPLY_ONE;
          end
        end
      end
      PH_OPEN, PH_CHECK: begin
        if (last_byte) begin
          res.reply_valid = 1'b1;
          if (match) begin
            res.reply_byte = REPLY_ONE;
            fail_nxt       = '0;
            res.door_cycle = (phase_r == PH_OPEN);
          end else begin
            res.reply_byte = REPLY_ZERO;
            fail_nxt       = fail_inc;
            res.alarm      = (fail_inc >= {4'd0, try_limit});
          end
        end
      end
      default: begin
      end
    endcase
    res.hold_seconds = hold_nxt;
  end

  // Control and key state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      byte_cnt_r  <= '0;
      key_valid_r <= 1'b0;
      fail_r      <= '0;
      hold_r      <= HOLD_RESET;
      key_r       <= {KEY_LENGTH{KEY_RESET_BYTE}};
    end else if (step) begin
      phase_r     <= phase_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      key_valid_r <= key_valid_nxt;
      fail_r      <= fail_nxt;
      hold_r      <= hold_nxt;
      if (store_key) begin
        key_r <= cand;
      end
    end
  end

  // Entry buffer; earlier bytes of an entry are compared from here, the current byte straight from the input.
  always_ff @(posedge clk) begin
    if (step && collecting) begin
      entry_r[idx] <= rx_byte;
    end
  end

`ifndef SYNTH
  // A stored key makes the key valid from then on.
  a_key_valid_after_save: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.key_saved |=> key_valid_r)
    else $error("key_valid not set after a key was stored");

  // The alarm on a mismatch only fires at or above the limit.
  a_alarm_limit: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.alarm && phase_r != PH_IDLE |-> fail_nxt >= {4'd0, try_limit})
    else $error("alarm raised below the try limit");

  // The byte counter stays below the key length.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r < CW'(KEY_LENGTH))
    else $error("byte counter out of range");

  // Outside the collect phases the counter rests at zero.
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && !collecting && phase_nxt != PH_IDLE |=> byte_cnt_r == '0)
    else $error("byte counter not cleared on entering a collect phase");
`endif

endmodule

// ===== rtl/password_lock_command_engine.sv =====
// ----------------------------------------------------------------------------
// password_lock_command_engine: serial lock command protocol
// Input register, single-pass command engine and result register.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one received byte, and each
// byte produces exactly one result transfer carrying the reply (if any),
// the current hold time and the door, alarm and persistence event pulses.
// The block sustains one byte per clock cycle while out_ready stays high; a
// byte passes through the input register and then the result register, with
// the single combinational pass of the command decode and the parallel key
// compare between those two registers. While a result waits for out_ready,
// the input side accepts a byte only while the input register is empty. The
// try limit is to be written through cfg_wr_en and cfg_wr_data only while
// no byte is in flight, which the block does not enforce; it resets to 3.
// ----------------------------------------------------------------------------
module password_lock_command_engine #(
  parameter int KEY_LENGTH = plce_pkg::KEY_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  // Result channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_reply_valid,
  output logic [7:0] out_reply_byte,
  output logic       out_door_cycle,
  output logic [7:0] out_hold_seconds,
  output logic       out_alarm,
  output logic       out_key_saved,
  output logic       out_time_saved,
  // Configuration port.
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  import plce_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  result_t    out_res_r;
  result_t    res;
  logic [3:0] try_limit_r;
  logic       advance;
  logic       in_fire;

  // The input register moves forward when the result register is empty or its result is taken.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_fire  = in_valid && in_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      try_limit_r <= TRY_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      try_limit_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_rx_byte;
    end
  end

  plce_engine #(
    .KEY_LENGTH(KEY_LENGTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .try_limit (try_limit_r),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_reply_valid  = out_res_r.reply_valid;
  assign out_reply_byte   = out_res_r.reply_byte;
  assign out_door_cycle   = out_res_r.door_cycle;
  assign out_hold_seconds = out_res_r.hold_seconds;
  assign out_alarm        = out_res_r.alarm;
  assign out_key_saved    = out_res_r.key_saved;
  assign out_time_saved   = out_res_r.time_saved;

`ifndef SYNTH
  // Without a reply the reply byte reads as zero.
  a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reply_valid |-> out_reply_byte == 8'h00)
    else $error("reply byte set without a reply");

  // A door cycle always comes with a positive reply.
  a_door_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_door_cycle |-> out_reply_valid && out_reply_byte == REPLY_ONE)
    else $error("door cycle without a positive reply");

  // A byte in the input register that cannot move forward stays put.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_byte_r))
    else $error("input register lost a stalled byte");

  // Every byte taken from the input register lands in the result register.
  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result register not loaded");
`endif

endmodule

// ===== verif/tb_password_lock_command_engine.sv =====
// ----------------------------------------------------------------------------
// tb_password_lock_command_engine: self-checking bench for the lock engine
// Drives received bytes through the valid/ready input channel, predicts every
// result transfer with a cycle-free model of the command protocol and compares
// the result channel field by field, over several try limit settings.
// ----------------------------------------------------------------------------
module tb_password_lock_command_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import plce_pkg::*;

  localparam int          KEY_LEN     = KEY_LENGTH_DEF;
  localparam int unsigned BYTE_TARGET = 1950;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic [KEY_LEN-1:0][7:0] key_bytes_t;

  // Opening sequence: replies without a key, lockout, an ignored byte, the
  // top hold time, a key change that holds command letters, a check that
  // ends early on a shared zero byte, and an open that moves the door.
  localparam logic [7:0] OPENING_BYTES [25] = '{
    CMD_QUERY, CMD_OPEN, CMD_CHECK, CMD_LOCK, 8'hFF,
    CMD_TIME, 8'hFF,
    CMD_CHANGE, CMD_OPEN, 8'h00, CMD_QUERY, 8'hFF, 8'h37,
    CMD_CHECK, CMD_OPEN, 8'h00, 8'h12, 8'h34, 8'h56,
    CMD_OPEN, CMD_OPEN, 8'h00, CMD_QUERY, 8'hFF, 8'h37
  };

  // Protocol model and store of the results still to come.
  class lock_reply_scoreboard;
    phase_t      lock_phase;
    int unsigned entry_count;
    key_bytes_t  entry_bytes;
    key_bytes_t  stored_key;
    bit          key_valid;
    logic [7:0]  fail_count;
    logic [7:0]  hold_time;
    logic [3:0]  try_limit;
    result_t     expected_replies[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      lock_phase   = PH_IDLE;
      entry_count  = 0;
      entry_bytes  = '0;
      stored_key   = {KEY_LEN{KEY_RESET_BYTE}};
      key_valid    = 1'b0;
      fail_count   = '0;
      hold_time    = HOLD_RESET;
      try_limit    = TRY_LIMIT_RESET;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // Bytes are compared in order; a zero byte shared by both ends the
    // compare as a match.
    function bit entry_matches_key();
      for (int i = 0; i < KEY_LEN; i++) begin
        if (entry_bytes[i] != stored_key[i]) return 1'b0;
        if (entry_bytes[i] == 8'h00) return 1'b1;
      end
      return 1'b1;
    endfunction

    // Advances the protocol by one accepted byte and queues its result.
    function void note_received_byte(logic [7:0] rx);
      result_t r;
      r = '0;
      case (lock_phase)
        PH_IDLE: begin
          case (rx)
            CMD_QUERY: begin
              r.reply_valid = 1'b1;
              r.reply_byte  = key_valid ? REPLY_ONE : REPLY_ZERO;
            end
            CMD_SET, CMD_CHANGE: begin
              lock_phase  = (rx == CMD_SET) ? PH_SET : PH_CHANGE;
              entry_count = 0;
            end
            CMD_OPEN, CMD_CHECK: begin
              if (!key_valid) begin
                r.reply_valid = 1'b1;
                r.reply_byte  = (rx == CMD_OPEN) ? REPLY_ZERO : REPLY_NOKEY;
              end else begin
                lock_phase  = (rx == CMD_OPEN) ? PH_OPEN : PH_CHECK;
                entry_count = 0;
              end
            end
            CMD_TIME: lock_phase = PH_TIME;
            CMD_LOCK: begin
              fail_count = {4'd0, try_limit};
              r.alarm    = 1'b1;
            end
            default: ;
          endcase
        end
        PH_TIME: begin
          hold_time    = rx;
          r.time_saved = 1'b1;
          lock_phase   = PH_IDLE;
        end
        default: begin
          // While collecting, every byte is key data.
          entry_bytes[entry_count] = rx;
          entry_count++;
          if (entry_count == KEY_LEN) begin
            if (lock_phase == PH_SET || lock_phase == PH_CHANGE) begin
              stored_key  = entry_bytes;
              key_valid   = 1'b1;
              r.key_saved = 1'b1;
              if (lock_phase == PH_CHANGE) begin
                r.reply_valid = 1'b1;
                r.reply_byte  = REPLY_ONE;
              end
            end else if (entry_matches_key()) begin
              r.reply_valid = 1'b1;
              r.reply_byte  = REPLY_ONE;
              fail_count    = '0;
              if (lock_phase == PH_OPEN) r.door_cycle = 1'b1;
            end else begin
              r.reply_valid = 1'b1;
              r.reply_byte  = REPLY_ZERO;
              if (fail_count != FAIL_MAX) fail_count++;
              if (fail_count >= {4'd0, try_limit}) r.alarm = 1'b1;
            end
            lock_phase  = PH_IDLE;
            entry_count = 0;
          end
        end
      endcase
      r.hold_seconds = hold_time;
      expected_replies.push_back(r);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("[%0t] result %0d: %s got 0x%02h, expected 0x%02h",
                 $time, results_seen, what, got, want);
    endtask

    // Compares one result transfer with the oldest prediction.
    task check_reply(result_t got);
      result_t want;
      results_seen++;
      if (expected_replies.size() == 0) begin
        report("unexpected result, reply_byte", got.reply_byte, 8'h00);
        return;
      end
      want = expected_replies.pop_front();
      if (got.reply_valid !== want.reply_valid)
        report("reply_valid", 8'(got.reply_valid), 8'(want.reply_valid));
      if (got.reply_byte !== want.reply_byte)
        report("reply_byte", got.reply_byte, want.reply_byte);
      if (got.door_cycle !== want.door_cycle)
        report("door_cycle", 8'(got.door_cycle), 8'(want.door_cycle));
      if (got.hold_seconds !== want.hold_seconds)
        report("hold_seconds", got.hold_seconds, want.hold_seconds);
      if (got.alarm !== want.alarm)
        report("alarm", 8'(got.alarm), 8'(want.alarm));
      if (got.key_saved !== want.key_saved)
        report("key_saved", 8'(got.key_saved), 8'(want.key_saved));
      if (got.time_saved !== want.time_saved)
        report("time_saved", 8'(got.time_saved), 8'(want.time_saved));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_reply_valid;
  logic [7:0] out_reply_byte;
  logic       out_door_cycle;
  logic [7:0] out_hold_seconds;
  logic       out_alarm;
  logic       out_key_saved;
  logic       out_time_saved;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;
  result_t    observed;

  lock_reply_scoreboard lock_model;
  bit          sender_idles    = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned bytes_sent      = 0;
  int unsigned cycle_count     = 0;

  password_lock_command_engine #(
    .KEY_LENGTH(KEY_LEN)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reply_valid  (out_reply_valid),
    .out_reply_byte   (out_reply_byte),
    .out_door_cycle   (out_door_cycle),
    .out_hold_seconds (out_hold_seconds),
    .out_alarm        (out_alarm),
    .out_key_saved    (out_key_saved),
    .out_time_saved   (out_time_saved),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  assign observed = {out_reply_valid, out_reply_byte, out_door_cycle, out_hold_seconds,
                     out_alarm, out_key_saved, out_time_saved};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) lock_model.note_received_byte(in_rx_byte);
      if (out_valid && out_ready) lock_model.check_reply(observed);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The result side stalls in random bursts while stalls are enabled.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Random key: plain bytes, ASCII digits, or bytes with one zero in them.
  function automatic key_bytes_t random_key();
    key_bytes_t  k;
    int unsigned style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < KEY_LEN; i++) begin
      k[i] = 8'($urandom_range(0, 255));
      if (style == 1) k[i] = 8'h30 + 8'($urandom_range(0, 9));
    end
    if (style == 2) k[$urandom_range(0, KEY_LEN - 1)] = 8'h00;
    return k;
  endfunction

  // Entry for an open or check: exact, equal up to the key's first zero,
  // a near miss at or before that zero, or random bytes.
  function automatic key_bytes_t make_entry(input key_bytes_t key, input bit allow_match);
    key_bytes_t  e;
    int unsigned stop;
    int unsigned p;
    int unsigned style;
    e    = random_key();
    stop = KEY_LEN - 1;
    for (int i = KEY_LEN - 1; i >= 0; i--)
      if (key[i] == 8'h00) stop = i;
    style = allow_match ? $urandom_range(0, 9) : $urandom_range(5, 9);
    if (style < 4) begin
      e = key;
    end else if (style < 5) begin
      for (int i = 0; i <= stop; i++) e[i] = key[i];
    end else if (style < 8) begin
      p = $urandom_range(0, stop);
      for (int i = 0; i < p; i++) e[i] = key[i];
      e[p] = key[p] ^ 8'($urandom_range(1, 255));
    end
    return e;
  endfunction

  function automatic logic [7:0] pick_hold_time();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
  endfunction

  // One input transfer, with an optional idle burst in front of it.
  task automatic send_byte(input logic [7:0] value, input bit counted);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) bytes_sent++;
  endtask

  // One command with its data bytes. In mismatch mode the opens and checks
  // carry near misses or random bytes, so the failure count climbs.
  task automatic send_command_sequence(input bit mismatch_only);
    int unsigned pick;
    int unsigned data_len;
    logic [7:0]  cmd;
    key_bytes_t  data;
    bit          counted;
    pick     = $urandom_range(0, 99);
    data     = random_key();
    data_len = 0;
    counted  = 1'b1;
    if (mismatch_only) begin
      if (pick < 90) begin
        cmd      = (pick < 45) ? CMD_OPEN : CMD_CHECK;
        data     = make_entry(lock_model.stored_key, 1'b0);
        data_len = KEY_LEN;
      end else if (pick < 94) begin
        cmd = CMD_QUERY;
      end else if (pick < 97) begin
        cmd      = CMD_TIME;
        data[0]  = pick_hold_time();
        data_len = 1;
      end else begin
        cmd      = CMD_SET;
        data_len = KEY_LEN;
      end
    end else if (pick < 10) begin
      cmd = CMD_QUERY;
    end else if (pick < 30) begin
      cmd      = (pick < 20) ? CMD_SET : CMD_CHANGE;
      data_len = KEY_LEN;
    end else if (pick < 75) begin
      cmd      = (pick < 55) ? CMD_OPEN : CMD_CHECK;
      data     = make_entry(lock_model.stored_key, 1'b1);
      data_len = KEY_LEN;
    end else if (pick < 85) begin
      cmd      = CMD_TIME;
      data[0]  = pick_hold_time();
      data_len = 1;
    end else if (pick < 90) begin
      cmd = CMD_LOCK;
    end else if (pick < 95) begin
      // A byte that is no command changes no state; its result carries no reply or event.
      do cmd = 8'($urandom_range(0, 255));
      while (cmd inside {CMD_QUERY, CMD_SET, CMD_CHANGE, CMD_OPEN, CMD_CHECK,
                         CMD_TIME, CMD_LOCK});
      counted = 1'b0;
    end else begin
      // Cut-short sequence: the bytes that follow are taken as key data.
      case ($urandom_range(0, 3))
        0:       cmd = CMD_SET;
        1:       cmd = CMD_CHANGE;
        2:       cmd = CMD_OPEN;
        default: cmd = CMD_CHECK;
      endcase
      data_len = $urandom_range(1, KEY_LEN - 1);
    end
    // Without a key, open and check reply at once and take no data.
    if ((cmd == CMD_OPEN || cmd == CMD_CHECK) && !lock_model.key_valid) data_len = 0;
    send_byte(cmd, counted);
    for (int i = 0; i < data_len; i++) send_byte(data[i], 1'b1);
  endtask

  task automatic run_phase(input int unsigned min_bytes, input bit mismatch_only);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < min_bytes) send_command_sequence(mismatch_only);
  endtask

  // Waits until every predicted result has been taken, plus a short margin.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lock_model.expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_try_limit(input logic [3:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    lock_model.try_limit = value;
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned saturated_runs;
    in_valid    = 1'b0;
    in_rx_byte  = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    lock_model  = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening with the reset value of the try limit.
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i], 1'b1);
    wait_until_drained();

    // A threshold of one, then of zero.
    write_try_limit(4'd1);
    run_phase(100, 1'b0);
    wait_until_drained();
    write_try_limit(4'd0);
    run_phase(100, 1'b0);
    wait_until_drained();

    // Highest threshold, with failures piling up past saturation.
    write_try_limit(4'd15);
    saturated_runs = 0;
    while (saturated_runs < 10) begin
      send_command_sequence(1'b1);
      if (lock_model.fail_count == FAIL_MAX) saturated_runs++;
    end
    wait_until_drained();

    // Last stretch at full rate with a random threshold.
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    write_try_limit(4'($urandom_range(0, 15)));
    run_phase((bytes_sent + 150 > BYTE_TARGET) ? 150 : BYTE_TARGET - bytes_sent, 1'b0);

    wait_until_drained();
    repeat (8) @(posedge clk);
    if (lock_model.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/plce_pkg.sv
rtl/plce_key_compare.sv
rtl/plce_engine.sv
rtl/password_lock_command_engine.sv
verif/tb_password_lock_command_engine.sv
